### hw/rtl/indexed_binary_min_heap_macros.svh
// Assertion macros for the indexed binary min-heap.
`ifndef INDEXED_BINARY_MIN_HEAP_MACROS_SVH
`define INDEXED_BINARY_MIN_HEAP_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define IBMH_ASSERT_NOW(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define IBMH_ASSERT_NEXT(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/ibmh_pkg.sv
// Shared types and constants of the indexed binary min-heap.
package ibmh_pkg;

  localparam int KEY_W   = 32;
  localparam int ID_W    = 10;
  localparam int SLOT_W  = 10;
  localparam int COUNT_W = 11;

  localparam int MAP_NEVER  = 0;
  localparam int MAP_CLOSED = 1;
  localparam int MAP_BASE   = 2;

  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [ID_W-1:0]    id_t;
  typedef logic [SLOT_W-1:0]  slot_t;
  typedef logic [COUNT_W-1:0] count_t;

  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_EXTRACT  = 2'd1,
    OP_DECREASE = 2'd2,
    OP_QUERY    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_ABSENT = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    NS_NEVER  = 2'd0,
    NS_OPEN   = 2'd1,
    NS_CLOSED = 2'd2
  } nstate_t;

  typedef struct packed {
    op_t  op;
    logic node_ok;
    id_t  node;
    key_t key;
  } cmd_t;

  typedef struct packed {
    status_t status;
    key_t    min_key;
    id_t     min_node;
    nstate_t node_state;
    slot_t   slot;
    count_t  entry_count;
  } rsp_t;

endpackage

### hw/rtl/ibmh_front.sv
// Front end: classifies incoming beats and queues them for the heap engine.
module ibmh_front #(
  parameter int NODE_COUNT = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [1:0]        kind,
  input  logic [9:0]        node_id,
  input  logic [31:0]       key,
  output logic              full,
  output logic              cmd_valid,
  output ibmh_pkg::cmd_t    cmd,
  input  logic              cmd_take
);

  ibmh_pkg::cmd_t q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  ibmh_pkg::cmd_t cls;

  always_comb begin
    cls.op      = ibmh_pkg::op_t'(kind);
    cls.node_ok = (32'(node_id) < NODE_COUNT);
    cls.node    = node_id;
    cls.key     = key;
  end

  assign full      = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        q_r[wp_r] <= cls;
        wp_r      <= ~wp_r;
      end
      if (cmd_take) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(cmd_take);
    end
  end

endmodule

### hw/rtl/ibmh_back.sv
// Heap engine: heap and position-map memories with the sift sequencer.
module ibmh_back #(
  parameter int CAPACITY   = 1024,
  parameter int NODE_COUNT = 1024,
  parameter int KEY_BITS   = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  input  ibmh_pkg::cmd_t cmd,
  output logic           cmd_take,
  output logic           clearing,
  output logic           out_valid,
  output ibmh_pkg::rsp_t rsp,
  input  logic           out_pop
);

  localparam int SW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int MW  = $clog2(CAPACITY + 2);
  localparam int NIW = $clog2(NODE_COUNT);
  localparam int KW  = KEY_BITS;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_EX_LAST, S_UP_RD, S_UP_CMP,
    S_DN_RD, S_DN_RR, S_DN_CMP, S_COMMIT
  } state_t;

  logic [KW-1:0]           key_mem [CAPACITY];
  logic [ibmh_pkg::ID_W-1:0] id_mem [CAPACITY];
  logic [MW-1:0]           map_mem [NODE_COUNT];

  logic                    ent_we, map_we;
  logic [SW-1:0]           ent_wa, ent_ra;
  logic [KW-1:0]           ent_wk, ent_key_q;
  ibmh_pkg::id_t           ent_wi, ent_id_q;
  logic [NIW-1:0]          map_wa, map_ra;
  logic [MW-1:0]           map_wd, map_q;

  state_t                  state_r, state_nxt;
  logic [CW-1:0]           fill_r, fill_nxt;
  logic [SW-1:0]           idx_r, idx_nxt;
  logic [KW-1:0]           cur_key_r, cur_key_nxt, ck_r, ck_nxt, key_r, key_nxt;
  ibmh_pkg::id_t           cur_id_r, cur_id_nxt, cid_r, cid_nxt, node_r, node_nxt;
  ibmh_pkg::op_t           op_r, op_nxt;
  logic                    ok_r, ok_nxt;
  logic [NIW-1:0]          clr_r, clr_nxt;
  logic [KW-1:0]           min_key_r, min_key_nxt;
  ibmh_pkg::id_t           min_id_r, min_id_nxt;
  logic                    out_valid_r, out_valid_nxt;
  ibmh_pkg::rsp_t          rsp_r, rsp_nxt;

  logic                    finish;
  ibmh_pkg::status_t       fin_status;
  ibmh_pkg::nstate_t       fin_ns;
  ibmh_pkg::slot_t         fin_slot;
  logic [SW-1:0]           par;
  logic [SW:0]             lc, rc;
  logic                    take_r;
  logic [KW-1:0]           sel_key;
  ibmh_pkg::id_t           sel_id;
  logic [SW-1:0]           sel_idx;
  logic [MW-1:0]           idx_map;

  always_ff @(posedge clk) begin
    if (ent_we) begin
      key_mem[ent_wa] <= ent_wk;
      id_mem[ent_wa]  <= ent_wi;
    end
    ent_key_q <= key_mem[ent_ra];
    ent_id_q  <= id_mem[ent_ra];
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_wa] <= map_wd;
    end
    map_q <= map_mem[map_ra];
  end

  assign par     = (idx_r - SW'(1)) >> 1;
  assign lc      = {idx_r, 1'b1};
  assign rc      = lc + (SW+1)'(1);
  assign idx_map = MW'(idx_r) + MW'(ibmh_pkg::MAP_BASE);
  assign take_r  = (32'(rc) < 32'(fill_r)) && (ck_r > ent_key_q);
  assign sel_key = take_r ? ent_key_q : ck_r;
  assign sel_id  = take_r ? ent_id_q : cid_r;
  assign sel_idx = take_r ? rc[SW-1:0] : lc[SW-1:0];

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    idx_nxt       = idx_r;
    cur_key_nxt   = cur_key_r;
    cur_id_nxt    = cur_id_r;
    ck_nxt        = ck_r;
    cid_nxt       = cid_r;
    key_nxt       = key_r;
    node_nxt      = node_r;
    op_nxt        = op_r;
    ok_nxt        = ok_r;
    clr_nxt       = clr_r;
    min_key_nxt   = min_key_r;
    min_id_nxt    = min_id_r;
    out_valid_nxt = out_valid_r & ~out_pop;
    rsp_nxt       = rsp_r;
    cmd_take      = 1'b0;
    ent_we        = 1'b0;
    ent_wa        = idx_r;
    ent_wk        = cur_key_r;
    ent_wi        = cur_id_r;
    ent_ra        = '0;
    map_we        = 1'b0;
    map_wa        = NIW'(cur_id_r);
    map_wd        = idx_map;
    map_ra        = NIW'(cmd.node);
    finish        = 1'b0;
    fin_status    = ibmh_pkg::ST_OK;
    fin_ns        = ibmh_pkg::NS_NEVER;
    fin_slot      = '0;

    unique case (state_r)
      S_CLEAR: begin
        map_we  = 1'b1;
        map_wa  = clr_r;
        map_wd  = MW'(ibmh_pkg::MAP_NEVER);
        clr_nxt = clr_r + NIW'(1);
        if (32'(clr_r) == NODE_COUNT - 1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_valid && !out_valid_r) begin
          cmd_take  = 1'b1;
          op_nxt    = cmd.op;
          ok_nxt    = cmd.node_ok;
          node_nxt  = cmd.node;
          key_nxt   = KW'(cmd.key);
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (op_r)
          ibmh_pkg::OP_INSERT: begin
            if (!ok_r || map_q != MW'(ibmh_pkg::MAP_NEVER)) begin
              finish     = 1'b1;
              fin_status = ibmh_pkg::ST_ABSENT;
            end else if (32'(fill_r) >= CAPACITY) begin
              finish     = 1'b1;
              fin_status = ibmh_pkg::ST_FULL;
            end else begin
              idx_nxt     = SW'(fill_r);
              fill_nxt    = fill_r + CW'(1);
              cur_key_nxt = key_r;
              cur_id_nxt  = node_r;
              state_nxt   = S_UP_RD;
            end
          end
          ibmh_pkg::OP_EXTRACT: begin
            if (fill_r == '0) begin
              finish     = 1'b1;
              fin_status = ibmh_pkg::ST_EMPTY;
            end else begin
              min_key_nxt = ent_key_q;
              min_id_nxt  = ent_id_q;
              map_we      = 1'b1;
              map_wa      = NIW'(ent_id_q);
              map_wd      = MW'(ibmh_pkg::MAP_CLOSED);
              fill_nxt    = fill_r - CW'(1);
              ent_ra      = SW'(fill_r - CW'(1));
              if (fill_r == CW'(1)) begin
                finish = 1'b1;
              end else begin
                state_nxt = S_EX_LAST;
              end
            end
          end
          ibmh_pkg::OP_DECREASE: begin
            if (!ok_r || map_q < MW'(ibmh_pkg::MAP_BASE) ||
                32'(map_q) - ibmh_pkg::MAP_BASE >= 32'(fill_r)) begin
              finish     = 1'b1;
              fin_status = ibmh_pkg::ST_ABSENT;
            end else begin
              idx_nxt     = SW'(map_q - MW'(ibmh_pkg::MAP_BASE));
              cur_key_nxt = key_r;
              cur_id_nxt  = node_r;
              state_nxt   = S_UP_RD;
            end
          end
          ibmh_pkg::OP_QUERY: begin
            finish = 1'b1;
            if (!ok_r) begin
              fin_status = ibmh_pkg::ST_ABSENT;
            end else if (map_q == MW'(ibmh_pkg::MAP_CLOSED)) begin
              fin_ns = ibmh_pkg::NS_CLOSED;
            end else if (map_q >= MW'(ibmh_pkg::MAP_BASE)) begin
              fin_ns   = ibmh_pkg::NS_OPEN;
              fin_slot = ibmh_pkg::slot_t'(map_q - MW'(ibmh_pkg::MAP_BASE));
            end
          end
          default: ;
        endcase
        if (finish) begin
          state_nxt = S_IDLE;
        end
      end
      S_EX_LAST: begin
        cur_key_nxt = ent_key_q;
        cur_id_nxt  = ent_id_q;
        idx_nxt     = '0;
        state_nxt   = S_DN_RD;
      end
      S_UP_RD: begin
        ent_ra = par;
        if (idx_r == '0) begin
          state_nxt = S_COMMIT;
        end else begin
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (ent_key_q > cur_key_r) begin
          ent_we    = 1'b1;
          ent_wk    = ent_key_q;
          ent_wi    = ent_id_q;
          map_we    = 1'b1;
          map_wa    = NIW'(ent_id_q);
          idx_nxt   = par;
          state_nxt = S_UP_RD;
        end else begin
          state_nxt = S_COMMIT;
        end
      end
      S_DN_RD: begin
        ent_ra = lc[SW-1:0];
        if (CW'(idx_r) < (fill_r >> 1)) begin
          state_nxt = S_DN_RR;
        end else begin
          state_nxt = S_COMMIT;
        end
      end
      S_DN_RR: begin
        ent_ra    = rc[SW-1:0];
        ck_nxt    = ent_key_q;
        cid_nxt   = ent_id_q;
        state_nxt = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (sel_key >= cur_key_r) begin
          state_nxt = S_COMMIT;
        end else begin
          ent_we    = 1'b1;
          ent_wk    = sel_key;
          ent_wi    = sel_id;
          map_we    = 1'b1;
          map_wa    = NIW'(sel_id);
          idx_nxt   = sel_idx;
          state_nxt = S_DN_RD;
        end
      end
      S_COMMIT: begin
        ent_we    = 1'b1;
        map_we    = 1'b1;
        finish    = 1'b1;
        state_nxt = S_IDLE;
      end
      default: ;
    endcase

    if (finish) begin
      out_valid_nxt      = 1'b1;
      rsp_nxt.status     = fin_status;
      rsp_nxt.node_state = fin_ns;
      rsp_nxt.slot       = fin_slot;
      rsp_nxt.entry_count = ibmh_pkg::count_t'(fill_nxt);
      if (op_r == ibmh_pkg::OP_EXTRACT && fin_status == ibmh_pkg::ST_OK) begin
        rsp_nxt.min_key  = ibmh_pkg::key_t'(min_key_nxt);
        rsp_nxt.min_node = min_id_nxt;
      end else begin
        rsp_nxt.min_key  = '0;
        rsp_nxt.min_node = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      cur_key_r   <= cur_key_nxt;
      cur_id_r    <= cur_id_nxt;
      ck_r        <= ck_nxt;
      cid_r       <= cid_nxt;
      key_r       <= key_nxt;
      node_r      <= node_nxt;
      op_r        <= op_nxt;
      ok_r        <= ok_nxt;
      min_key_r   <= min_key_nxt;
      min_id_r    <= min_id_nxt;
      rsp_r       <= rsp_nxt;
    end
  end

  assign clearing  = (state_r == S_CLEAR);
  assign out_valid = out_valid_r;
  assign rsp       = rsp_r;

endmodule

### hw/rtl/indexed_binary_min_heap.sv
// Indexed binary min-heap with decrease-key, one result per command.
// After reset every position-map entry is cleared with in_full held high.
// Commands then pass a two-beat queue into a sequencer that owns simple
// dual-port heap and map memories. Rejected commands, queries and extracts
// of the last entry finish in the decode state; insert and decrease sift the
// entry up toward the root, extract moves the last entry to the root and sifts
// it down, and each sift stops where the heap order already holds.
// The sequencer takes no new command until the previous result has been
// popped, so one result waits in an output register while the next command
// is queued.
`include "indexed_binary_min_heap_macros.svh"

module indexed_binary_min_heap #(
  parameter int CAPACITY   = 1024,
  parameter int NODE_COUNT = 1024,
  parameter int KEY_BITS   = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_kind,
  input  logic [9:0]  in_node_id,
  input  logic [31:0] in_key,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [1:0]  out_status,
  output logic [31:0] out_min_key,
  output logic [9:0]  out_min_node,
  output logic [1:0]  out_node_state,
  output logic [9:0]  out_slot,
  output logic [10:0] out_entry_count
);

  logic           front_full, clearing, cmd_valid, cmd_take, out_valid, push_ok;
  logic           rsp_empty_st, rsp_full_st, rsp_has_state;
  ibmh_pkg::cmd_t cmd;
  ibmh_pkg::rsp_t rsp;

  assign in_full = front_full | clearing;
  assign push_ok = in_push & ~in_full;

  ibmh_front #(
    .NODE_COUNT(NODE_COUNT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push_ok),
    .kind     (in_kind),
    .node_id  (in_node_id),
    .key      (in_key),
    .full     (front_full),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_take (cmd_take)
  );

  ibmh_back #(
    .CAPACITY  (CAPACITY),
    .NODE_COUNT(NODE_COUNT),
    .KEY_BITS  (KEY_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_take (cmd_take),
    .clearing (clearing),
    .out_valid(out_valid),
    .rsp      (rsp),
    .out_pop  (out_pop)
  );

  assign out_empty       = ~out_valid;
  assign out_status      = rsp.status;
  assign out_min_key     = rsp.min_key;
  assign out_min_node    = rsp.min_node;
  assign out_node_state  = rsp.node_state;
  assign out_slot        = rsp.slot;
  assign out_entry_count = rsp.entry_count;

  assign rsp_empty_st  = ~out_empty & (out_status == ibmh_pkg::ST_EMPTY);
  assign rsp_full_st   = ~out_empty & (out_status == ibmh_pkg::ST_FULL);
  assign rsp_has_state = ~out_empty & (out_node_state != ibmh_pkg::NS_NEVER);

  `IBMH_ASSERT_NOW(a_empty_count, rsp_empty_st, out_entry_count == 11'd0, "empty with entries")
  `IBMH_ASSERT_NOW(a_full_count, rsp_full_st, out_entry_count == 11'(CAPACITY), "full too early")
  `IBMH_ASSERT_NOW(a_query_ok, rsp_has_state, out_status == ibmh_pkg::ST_OK, "state with error")
  `IBMH_ASSERT_NOW(a_clear_block, clearing, in_full, "input open during map sweep")

endmodule
